// ===== hw/rtl/multi_channel_periodic_timer_core_defines.svh =====
// Assertion macros for the periodic timer core.
// Used by mcpt_ctrl; expects clk and rst_n in scope.
`ifndef MULTI_CHANNEL_PERIODIC_TIMER_CORE_DEFINES_SVH
`define MULTI_CHANNEL_PERIODIC_TIMER_CORE_DEFINES_SVH

// checked only while out of reset
`define MCPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MCPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mcpt_pkg.sv =====
// Shared types and codes for the periodic timer core.
// No dependencies.
`default_nettype none

package mcpt_pkg;

  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned FUNC_W       = 3;
  localparam int unsigned CH_W         = 6;
  localparam int unsigned CNT_W        = 31;
  localparam int unsigned USED_W       = 7;
  localparam int unsigned EV_W         = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_ADD    = 3'd1,
    FN_DELETE = 3'd2,
    FN_STOP   = 3'd3,
    FN_START  = 3'd4,
    FN_NEWIV  = 3'd5
  } func_t;

  typedef enum logic [EV_W-1:0] {
    EV_ACK    = 2'd0,
    EV_FIRE   = 2'd1,
    EV_NOFIRE = 2'd2
  } event_t;

  // one timer channel as held in a cell
  typedef struct packed {
    logic             occ;
    logic             run;
    logic [CNT_W-1:0] reload;
    logic [CNT_W-1:0] remain;
  } chan_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [CH_W-1:0]   channel;
    logic              ok;
    logic              channel_running;
    logic [USED_W-1:0] used_count;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcpt_cell.sv =====
// One timer channel register in the rotating ring.
// Depends on mcpt_pkg.
`default_nettype none

module mcpt_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           shift_en,
  input  wire mcpt_pkg::chan_t d,
  output mcpt_pkg::chan_t     q
);
  import mcpt_pkg::*;

  logic             occ_r;
  logic             run_r;
  logic [CNT_W-1:0] reload_r;
  logic [CNT_W-1:0] remain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      run_r <= 1'b0;
    end else if (shift_en) begin
      occ_r <= d.occ;
      run_r <= d.run;
    end
  end

  // counts of a free channel are never looked at, so they need no reset
  always_ff @(posedge clk) begin
    if (shift_en) begin
      reload_r <= d.reload;
      remain_r <= d.remain;
    end
  end

  assign q = {occ_r, run_r, reload_r, remain_r};

endmodule

`default_nettype wire

// ===== hw/rtl/mcpt_ctrl.sv =====
// Sequencer, head-of-ring update logic and result register.
// Depends on mcpt_pkg and the assertion macro header.
`default_nettype none
`include "multi_channel_periodic_timer_core_defines.svh"

module mcpt_ctrl #(
  parameter int unsigned CHANNELS = mcpt_pkg::CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mcpt_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [mcpt_pkg::CH_W-1:0]     in_handle,
  input  wire logic [mcpt_pkg::CNT_W-1:0]    in_interval,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output mcpt_pkg::res_t                     out_res,
  input  wire mcpt_pkg::chan_t               head,
  output mcpt_pkg::chan_t                    tail,
  output logic                               shift_en
);
  import mcpt_pkg::*;

  localparam int unsigned SW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [CH_W-1:0]   handle_r;
  logic [CNT_W-1:0]  iv_r;
  logic              inr_r;
  logic [USED_W-1:0] used_r, used_nxt;
  logic              found_r, found_nxt;
  logic [CH_W-1:0]   found_ch_r, found_ch_nxt;
  logic              hit_ok_r, hit_ok_nxt;
  logic              hit_run_r, hit_run_nxt;
  logic              pend_r, pend_nxt;
  logic [CH_W-1:0]   pend_ch_r, pend_ch_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;

  logic            accept, out_free, fire, advance, hit, last_step;
  logic [CH_W-1:0] step_ch;
  res_t            fin_res;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign step_ch   = CH_W'(step_r);
  assign hit       = inr_r && (step_ch == handle_r);
  assign last_step = (step_r == SW'(CHANNELS - 1));
  assign in_ready  = (state_r == ST_IDLE);

  // head update: the channel at the head of the ring is channel step_r
  always_comb begin
    tail        = head;
    fire        = 1'b0;
    used_nxt    = used_r;
    found_nxt   = found_r;
    found_ch_nxt = found_ch_r;
    hit_ok_nxt  = hit_ok_r;
    hit_run_nxt = hit_run_r;
    unique case (func_r)
      FN_TICK: begin
        if (head.occ && head.run) begin
          if (head.remain > CNT_W'(1)) begin
            tail.remain = head.remain - CNT_W'(1);
          end else begin
            tail.remain = head.reload;
            fire        = 1'b1;
          end
        end
      end
      FN_ADD: begin
        if (!head.occ && !found_r) begin
          tail.occ     = 1'b1;
          tail.run     = 1'b1;
          tail.reload  = iv_r;
          tail.remain  = iv_r;
          found_nxt    = 1'b1;
          found_ch_nxt = step_ch;
          used_nxt     = used_r + USED_W'(1);
        end
      end
      FN_DELETE: begin
        if (hit) begin
          tail        = '0;
          hit_ok_nxt  = 1'b1;
          hit_run_nxt = 1'b0;
          if (head.occ && (used_r != '0)) begin
            used_nxt = used_r - USED_W'(1);
          end
        end
      end
      FN_STOP: begin
        if (hit) begin
          tail.run    = 1'b0;
          hit_ok_nxt  = 1'b1;
          hit_run_nxt = 1'b0;
        end
      end
      FN_START: begin
        if (hit) begin
          hit_ok_nxt  = head.occ;
          hit_run_nxt = head.run;
          if (head.occ && !head.run) begin
            tail.remain = head.reload;
            tail.run    = 1'b1;
            hit_run_nxt = 1'b1;
          end
        end
      end
      FN_NEWIV: begin
        if (hit) begin
          hit_ok_nxt  = head.occ;
          hit_run_nxt = head.run;
          if (head.occ) begin
            tail.reload = iv_r;
            tail.remain = iv_r;
            tail.run    = 1'b1;
            hit_run_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // a second firing channel can only move on once the held one leaves
  assign advance  = !(fire && pend_r) || out_free;
  assign shift_en = (state_r == ST_WALK) && advance;

  always_comb begin
    fin_res            = '0;
    fin_res.used_count = used_r;
    fin_res.last       = 1'b1;
    fin_res.event_res  = EV_ACK;
    fin_res.channel    = handle_r;
    priority if (func_r == FN_TICK) begin
      fin_res.ok = 1'b1;
      if (pend_r) begin
        fin_res.event_res       = EV_FIRE;
        fin_res.channel         = pend_ch_r;
        fin_res.channel_running = 1'b1;
      end else begin
        fin_res.event_res = EV_NOFIRE;
        fin_res.channel   = '0;
      end
    end else if (func_r == FN_ADD) begin
      fin_res.ok              = found_r;
      fin_res.channel_running = found_r;
      fin_res.channel         = found_r ? found_ch_r : '0;
    end else if (inr_r && (func_r <= FN_NEWIV)) begin
      fin_res.ok              = hit_ok_r;
      fin_res.channel_running = hit_run_r;
    end else begin
      fin_res.ok              = 1'b0;
      fin_res.channel_running = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pend_nxt      = pend_r;
    pend_ch_nxt   = pend_ch_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WALK;
          step_nxt  = '0;
          pend_nxt  = 1'b0;
        end
      end
      ST_WALK: begin
        if (advance) begin
          if (fire) begin
            if (pend_r) begin
              out_nxt                 = '0;
              out_nxt.event_res       = EV_FIRE;
              out_nxt.channel         = pend_ch_r;
              out_nxt.ok              = 1'b1;
              out_nxt.channel_running = 1'b1;
              out_nxt.used_count      = used_r;
              out_nxt.last            = 1'b0;
              out_valid_nxt           = 1'b1;
            end
            pend_nxt    = 1'b1;
            pend_ch_nxt = step_ch;
          end
          if (last_step) begin
            state_nxt = ST_FIN;
          end else begin
            step_nxt = step_r + SW'(1);
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_nxt       = fin_res;
          out_valid_nxt = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      hit_ok_r    <= 1'b0;
      hit_run_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        found_r   <= 1'b0;
        hit_ok_r  <= 1'b0;
        hit_run_r <= 1'b0;
      end else if (shift_en) begin
        used_r    <= used_nxt;
        found_r   <= found_nxt;
        hit_ok_r  <= hit_ok_nxt;
        hit_run_r <= hit_run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_ch_r <= pend_ch_nxt;
    out_r     <= out_nxt;
    if (accept) begin
      func_r   <= in_func;
      handle_r <= in_handle;
      iv_r     <= in_interval;
      inr_r    <= ({1'b0, in_handle} < (CH_W + 1)'(CHANNELS));
    end
    if (shift_en) begin
      found_ch_r <= found_ch_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `MCPT_ASSERT(a_used_bound, (used_r <= USED_W'(CHANNELS)), "used count beyond bank size")
  `MCPT_ASSERT(a_walk_hold, (state_r == ST_WALK && !advance) |=> $stable(step_r),
               "ring moved during output stall")
  `MCPT_ASSERT(a_pend_idle, (state_r == ST_IDLE) |-> !pend_r, "held fire left over at idle")
  `MCPT_ASSERT_ALWAYS(a_rst_idle, (!rst_n) |=> (state_r == ST_IDLE && !out_valid_r),
                      "sequencer not idle after reset")

endmodule

`default_nettype wire

// ===== hw/rtl/multi_channel_periodic_timer_core.sv =====
// Channel     | Signals                                   | Handshake
// in          | in_func, in_handle, in_interval           | in_valid / in_ready
// out         | out_event_res, out_channel, out_ok,       | out_valid / out_ready
//             | out_channel_running, out_used_count, out_last
//
// Every transaction walks the ring of CHANNELS cells once, one cell per cycle unless the
// walk is stalled as described below, through the single head update unit.
// Reset frees every channel at once; no clearing pass.
// A tick with several firing channels stalls the walk while out_ready is low and a
// second fire result is waiting behind the output register.
// Depends on mcpt_pkg, mcpt_cell and mcpt_ctrl.
`default_nettype none

module multi_channel_periodic_timer_core #(
  parameter int unsigned CHANNELS = mcpt_pkg::CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mcpt_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [mcpt_pkg::CH_W-1:0]      in_handle,
  input  wire logic [mcpt_pkg::CNT_W-1:0]     in_interval,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mcpt_pkg::EV_W-1:0]           out_event_res,
  output logic [mcpt_pkg::CH_W-1:0]           out_channel,
  output logic                                out_ok,
  output logic                                out_channel_running,
  output logic [mcpt_pkg::USED_W-1:0]         out_used_count,
  output logic                                out_last
);
  import mcpt_pkg::*;

  chan_t cell_q [CHANNELS];
  chan_t tail;
  logic  shift_en;
  res_t  res;

  // cell i takes from cell i+1; the last cell takes the updated head
  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    chan_t d;
    if (i == CHANNELS - 1) begin : g_end
      assign d = tail;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    mcpt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (d),
      .q        (cell_q[i])
    );
  end

  mcpt_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_handle   (in_handle),
    .in_interval (in_interval),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (res),
    .head        (cell_q[0]),
    .tail        (tail),
    .shift_en    (shift_en)
  );

  assign out_event_res       = res.event_res;
  assign out_channel         = res.channel;
  assign out_ok              = res.ok;
  assign out_channel_running = res.channel_running;
  assign out_used_count      = res.used_count;
  assign out_last            = res.last;

endmodule

`default_nettype wire
